FILE: hw/rtl/circular_lbp_bilinear_defines.svh
// assertion macros for the circular lbp block
// used by circular_lbp_bilinear.sv, expects clk_i and rst_ni in scope
`ifndef CIRCULAR_LBP_BILINEAR_DEFINES_SVH
`define CIRCULAR_LBP_BILINEAR_DEFINES_SVH

// same-cycle implication, off during reset
`define CLBP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CLBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/clbp_pkg.sv
// constants, types and the trig table of the circular lbp block
// no dependencies; used by circular_lbp_bilinear
`default_nettype none

package clbp_pkg;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_RADIUS    = 5;
  localparam int MAX_NEIGHBORS = 24;
  localparam int HEIGHT_LIMIT  = 2048;

  localparam int WIN       = 2 * MAX_RADIUS + 1;
  localparam int WIN_CELLS = WIN * WIN;
  localparam int SLOTS     = 2 * MAX_RADIUS;
  localparam int PIX_W     = 8;
  localparam int LINE_W    = SLOTS * PIX_W;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W     = 12;
  localparam int RAD_W     = 3;
  localparam int NBR_W     = 5;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W    = MAX_NEIGHBORS;
  localparam int CELL_W    = $clog2(WIN_CELLS);
  localparam int POS_W     = $clog2(WIN);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int K_W       = $clog2(MAX_NEIGHBORS);
  localparam int WGT_W     = 17;
  localparam int ROM_DEPTH = MAX_NEIGHBORS * MAX_NEIGHBORS;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_NEIGHBORS = 2'd3
  } cfg_reg_e;

  // one sampling point: four window cells and their bilinear weights
  typedef struct packed {
    logic [CELL_W-1:0] cell_ff;
    logic [CELL_W-1:0] cell_fc;
    logic [CELL_W-1:0] cell_cf;
    logic [CELL_W-1:0] cell_cc;
    logic [WGT_W-1:0]  w_ff;
    logic [WGT_W-1:0]  w_fc;
    logic [WGT_W-1:0]  w_cf;
    logic [WGT_W-1:0]  w_cc;
  } point_t;

  typedef logic [63:0] trig_rom_t [ROM_DEPTH];

  // restoring division, elaboration only
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series for sin or cos in q30 over one quadrant
  function automatic longint series(longint unsigned phi, bit want_sin);
    longint unsigned t;
    longint unsigned dv;
    longint sum;
    int n;
    t = want_sin ? phi : ONE_Q30;
    sum = longint'(t);
    for (n = 1; n <= 7; n++) begin
      dv = want_sin ? longint'(2 * n) * longint'(2 * n + 1)
                    : longint'(2 * n - 1) * longint'(2 * n);
      t = (t * phi) >> 30;
      t = (t * phi) >> 30;
      t = udiv(t, dv);
      if ((n % 2) == 1) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return sum;
  endfunction

  // cos in the low word and sin in the high word, per point count and point
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned phi;
    longint sp;
    longint cp;
    longint c;
    longint s;
    int n;
    int k;
    for (n = 1; n <= MAX_NEIGHBORS; n++) begin
      for (k = 0; k < MAX_NEIGHBORS; k++) begin
        if (k < n) begin
          q   = udiv(longint'(4 * k), longint'(n));
          rem = longint'(4 * k) - q * longint'(n);
          phi = udiv(HALF_PI_Q30 * rem, longint'(n));
          sp  = series(phi, 1'b1);
          cp  = series(phi, 1'b0);
          case (q[1:0])
            2'd0: begin c = cp;  s = sp;  end
            2'd1: begin c = -sp; s = cp;  end
            2'd2: begin c = -cp; s = -sp; end
            default: begin c = sp; s = -cp; end
          endcase
          rom[(n - 1) * MAX_NEIGHBORS + k] = {s[31:0], c[31:0]};
        end else begin
          rom[(n - 1) * MAX_NEIGHBORS + k] = '0;
        end
      end
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

`default_nettype wire

FILE: hw/rtl/circular_lbp_bilinear.sv
// circular local binary pattern with bilinear sampling over a pixel stream
// depends on clbp_pkg and circular_lbp_bilinear_defines.svh
//
// Usage: gray pixels enter on the s_axis channel in raster order, one per
// transfer. For every interior pixel (row and column at least 2R) one code
// leaves on m_axis, tdata holding lbp_code and tlast marking the code of
// the bottom-right interior pixel of the frame. Border pixels give no code.
// Configuration is written on cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle; every write restarts the frame at column 0, row 0.
// Throughput is one pixel per clock while s_axis_tready is high. A code
// is formed from its pixel in steps: the line memory is read at the
// transfer, then the window shift, the pick of the sample pixels and the
// weighted sums; the code is then queued and leaves on m_axis in order.
// The line memory holds one word per column (all 2R stored lines of that
// column) and is read and written back once per pixel, with forwarding
// when consecutive pixels hit the same column.
// After reset and after each configuration write the sampling table is
// rebuilt, one point a cycle through a three-stage pipe (trig table read,
// offset rounding, weights); s_axis_tready is low meanwhile.
// Codes wait in an 8-entry output queue; when the receiver stalls,
// s_axis_tready falls once queued codes plus pixels in flight fill the queue.
`default_nettype none

module circular_lbp_bilinear (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel input: tdata = pixel[7:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [clbp_pkg::PIX_W-1:0]     s_axis_tdata,
  // code output: tdata = lbp_code[23:0]; tlast = last_of_frame
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [clbp_pkg::CODE_W-1:0]    m_axis_tdata,
  output logic                           m_axis_tlast,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [clbp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [clbp_pkg::CFG_W-1:0]     cfg_data_i
);
  import clbp_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] width_q, height_q;
  logic [RAD_W-1:0] radius_q;
  logic [NBR_W-1:0] nbr_q;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0] r_eff;
  logic [NBR_W-1:0] n_eff;
  logic [POS_W-1:0] d_eff;

  // clamped settings
  always_comb begin
    w_eff = (width_q == '0) ? DIM_W'(1)
          : ((width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q);
    h_eff = (height_q == '0) ? DIM_W'(1)
          : ((height_q > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) : height_q);
    r_eff = (radius_q == '0) ? RAD_W'(1)
          : ((radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q);
    n_eff = (nbr_q == '0) ? NBR_W'(1)
          : ((nbr_q > NBR_W'(MAX_NEIGHBORS)) ? NBR_W'(MAX_NEIGHBORS) : nbr_q);
    d_eff = {r_eff, 1'b0};
  end

  // ------------------------------------------------------------------
  // sampling table build, three stages per point
  logic                sw_a_v_q, sw_r_v_q, sw_b_v_q;
  logic [K_W-1:0]      sw_k_q, sw_r_k_q, sw_b_k_q;
  logic signed [12:0]  sw_vx_q, sw_vy_q;
  point_t              pt_q [MAX_NEIGHBORS];
  logic                busy;

  logic [ROM_AW-1:0]   rom_idx;
  logic [63:0]         rom_q;

  function automatic logic signed [12:0] to_q8(input logic signed [31:0] v,
                                               input logic [RAD_W-1:0] r,
                                               input logic flip);
    logic [31:0] mag_v;
    logic [34:0] prod;
    logic [12:0] m;
    logic        neg;
    mag_v = v[31] ? 32'(-v) : 32'(v);
    prod  = {3'b0, mag_v} * {32'b0, r};
    m     = 13'((prod + 35'(1 << 21)) >> 22);
    neg   = v[31] ^ flip;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [POS_W-1:0] place(input logic signed [4:0] off,
                                             input logic [RAD_W-1:0] r,
                                             input logic [POS_W-1:0] d);
    logic signed [5:0] p;
    p = $signed({3'b0, r}) + 6'(off);
    if (p < 0) return '0;
    else if (p > $signed({2'b0, d})) return d;
    else return p[POS_W-1:0];
  endfunction

  assign rom_idx  = ROM_AW'((ROM_AW'(n_eff) - ROM_AW'(1)) * ROM_AW'(MAX_NEIGHBORS))
                  + ROM_AW'(sw_k_q);

  // split offsets into floor, ceiling and fraction, form weights
  logic signed [4:0] fl_x, fl_y, ce_x, ce_y;
  logic [7:0]        tx, ty;
  logic [8:0]        ax, ay;
  logic [POS_W-1:0]  pr_f, pr_c, pc_f, pc_c;
  point_t            pt_new;

  always_comb begin
    fl_x = sw_vx_q[12:8];
    fl_y = sw_vy_q[12:8];
    tx   = sw_vx_q[7:0];
    ty   = sw_vy_q[7:0];
    ce_x = fl_x + 5'(tx != '0);
    ce_y = fl_y + 5'(ty != '0);
    ax   = 9'd256 - {1'b0, tx};
    ay   = 9'd256 - {1'b0, ty};
    pr_f = place(fl_y, r_eff, d_eff);
    pr_c = place(ce_y, r_eff, d_eff);
    pc_f = place(fl_x, r_eff, d_eff);
    pc_c = place(ce_x, r_eff, d_eff);
    pt_new.cell_ff = CELL_W'(pr_f) * CELL_W'(WIN) + CELL_W'(pc_f);
    pt_new.cell_fc = CELL_W'(pr_f) * CELL_W'(WIN) + CELL_W'(pc_c);
    pt_new.cell_cf = CELL_W'(pr_c) * CELL_W'(WIN) + CELL_W'(pc_f);
    pt_new.cell_cc = CELL_W'(pr_c) * CELL_W'(WIN) + CELL_W'(pc_c);
    pt_new.w_ff = WGT_W'({9'b0, ax} * {9'b0, ay});
    pt_new.w_fc = WGT_W'({10'b0, tx} * {9'b0, ay});
    pt_new.w_cf = WGT_W'({9'b0, ax} * {10'b0, ty});
    pt_new.w_cc = WGT_W'({10'b0, tx} * {10'b0, ty});
  end

  assign busy = sw_a_v_q | sw_r_v_q | sw_b_v_q;

  // ------------------------------------------------------------------
  // frame position and pipeline control
  logic             accept, pop, push;
  logic [COL_W-1:0] col_q, row_q;
  logic [POS_W-1:0] rm_q;
  logic             s1_v_q, s2_v_q, s3_v_q;
  logic             s1_emit_q, s2_emit_q, s3_emit_q;
  logic             s1_last_q, s2_last_q, s3_last_q;
  logic             s1_fwd_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic [POS_W-1:0] s1_rm_q;
  logic [FIFO_CW-1:0] fifo_cnt_q;
  logic [FIFO_CW-1:0] pending;
  logic             col_end, row_end;

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign pending = fifo_cnt_q + FIFO_CW'(s1_v_q) + FIFO_CW'(s2_v_q) + FIFO_CW'(s3_v_q);
  assign s_axis_tready = !busy && (pending < FIFO_CW'(FIFO_DEPTH));
  assign col_end = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
  assign row_end = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      radius_q <= RAD_W'(1);
      nbr_q    <= NBR_W'(8);
      sw_a_v_q <= 1'b1;
      sw_r_v_q <= 1'b0;
      sw_b_v_q <= 1'b0;
      sw_k_q   <= '0;
      sw_r_k_q <= '0;
      sw_b_k_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      rm_q     <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
    end else begin
      // table build sweep
      sw_r_v_q <= sw_a_v_q;
      sw_r_k_q <= sw_k_q;
      sw_b_v_q <= sw_r_v_q;
      sw_b_k_q <= sw_r_k_q;
      if (sw_a_v_q) begin
        if (sw_k_q == K_W'(MAX_NEIGHBORS - 1)) sw_a_v_q <= 1'b0;
        else sw_k_q <= sw_k_q + K_W'(1);
      end
      // frame position
      if (accept) begin
        if (col_end) begin
          col_q <= '0;
          if (row_end) begin
            row_q <= '0;
            rm_q  <= '0;
          end else begin
            row_q <= row_q + COL_W'(1);
            rm_q  <= (rm_q + POS_W'(1) == d_eff) ? '0 : rm_q + POS_W'(1);
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      // configuration write restarts frame and table
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WIDTH:     width_q  <= cfg_data_i;
          REG_HEIGHT:    height_q <= cfg_data_i;
          REG_RADIUS:    radius_q <= cfg_data_i[RAD_W-1:0];
          REG_NEIGHBORS: nbr_q    <= cfg_data_i[NBR_W-1:0];
          default: ;
        endcase
        col_q    <= '0;
        row_q    <= '0;
        rm_q     <= '0;
        sw_a_v_q <= 1'b1;
        sw_k_q   <= '0;
      end
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // table payload: trig table read, offset rounding, point write
  always_ff @(posedge clk_i) begin
    if (sw_a_v_q) rom_q <= TRIG_ROM[rom_idx];
    if (sw_r_v_q) begin
      sw_vx_q <= to_q8(rom_q[31:0], r_eff, 1'b0);
      sw_vy_q <= to_q8(rom_q[63:32], r_eff, 1'b1);
    end
    if (sw_b_v_q) pt_q[sw_b_k_q] <= pt_new;
  end

  // stage 1 payload captured at the pixel transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= s_axis_tdata;
      s1_col_q  <= col_q;
      s1_rm_q   <= rm_q;
      s1_emit_q <= (DIM_W'(row_q) >= DIM_W'(d_eff)) && (DIM_W'(col_q) >= DIM_W'(d_eff));
      s1_last_q <= row_end && col_end;
      s1_fwd_q  <= s1_v_q && (s1_col_q == col_q);
    end
    s2_emit_q <= s1_emit_q;
    s2_last_q <= s1_last_q;
    s3_emit_q <= s2_emit_q;
    s3_last_q <= s2_last_q;
  end

  // ------------------------------------------------------------------
  // line memory: one word per column holding every stored line
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q, wr_word_q, line_word, wr_word;
  logic [PIX_W-1:0]  new_col [WIN];

  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= line_mem[col_q];
    if (s1_v_q) begin
      line_mem[s1_col_q] <= wr_word;
      wr_word_q          <= wr_word;
    end
  end

  // new window column and write-back word
  always_comb begin
    logic [SLOT_W:0] sidx;
    line_word = s1_fwd_q ? wr_word_q : rd_q;
    wr_word   = line_word;
    for (int i = 0; i < SLOTS; i++) begin
      if (POS_W'(i) == s1_rm_q) wr_word[i*PIX_W +: PIX_W] = s1_pix_q;
    end
    for (int i = 0; i < WIN; i++) begin
      sidx = (SLOT_W + 1)'(s1_rm_q) + (SLOT_W + 1)'(i);
      if (sidx >= (SLOT_W + 1)'(d_eff)) sidx = sidx - (SLOT_W + 1)'(d_eff);
      if (POS_W'(i) < d_eff) new_col[i] = line_word[sidx[SLOT_W-1:0]*PIX_W +: PIX_W];
      else if (POS_W'(i) == d_eff) new_col[i] = s1_pix_q;
      else new_col[i] = '0;
    end
  end

  // window shift, newest column sits at column 2R
  logic [PIX_W-1:0] win_q [WIN_CELLS];

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          if (POS_W'(j) == d_eff) win_q[i*WIN+j] <= new_col[i];
          else if (j < WIN - 1) win_q[i*WIN+j] <= win_q[i*WIN+j+1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // pick sample pixels, then weighted sums and compare
  logic [PIX_W-1:0] pk_q [MAX_NEIGHBORS][4];
  logic [PIX_W-1:0] ctr_q;
  logic [CELL_W-1:0] ctr_cell;
  logic [CODE_W-1:0] code;

  assign ctr_cell = CELL_W'(r_eff) * CELL_W'(WIN + 1);

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      for (int k = 0; k < MAX_NEIGHBORS; k++) begin
        pk_q[k][0] <= win_q[pt_q[k].cell_ff];
        pk_q[k][1] <= win_q[pt_q[k].cell_fc];
        pk_q[k][2] <= win_q[pt_q[k].cell_cf];
        pk_q[k][3] <= win_q[pt_q[k].cell_cc];
      end
      ctr_q <= win_q[ctr_cell];
    end
  end

  always_comb begin
    logic [26:0] sum;
    for (int k = 0; k < MAX_NEIGHBORS; k++) begin
      sum = 27'({8'b0, pt_q[k].w_ff} * {17'b0, pk_q[k][0]})
          + 27'({8'b0, pt_q[k].w_fc} * {17'b0, pk_q[k][1]})
          + 27'({8'b0, pt_q[k].w_cf} * {17'b0, pk_q[k][2]})
          + 27'({8'b0, pt_q[k].w_cc} * {17'b0, pk_q[k][3]});
      code[k] = (sum > {3'b0, ctr_q, 16'b0}) && (NBR_W'(k) < n_eff);
    end
  end

  // ------------------------------------------------------------------
  // output queue
  logic [CODE_W:0]    fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;

  assign push = s3_v_q & s3_emit_q;
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + FIFO_AW'(1);
      if (pop)  rp_q <= rp_q + FIFO_AW'(1);
      fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_mem[wp_q] <= {s3_last_q, code};
  end

  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = fifo_mem[rp_q][CODE_W-1:0];
  assign m_axis_tlast  = fifo_mem[rp_q][CODE_W];

  // ------------------------------------------------------------------
  // checks
`include "circular_lbp_bilinear_defines.svh"

  `CLBP_ASSERT(a_fifo_no_overflow, push && !pop, fifo_cnt_q < FIFO_CW'(FIFO_DEPTH), "queue overflow")
  `CLBP_ASSERT(a_fwd_needs_prev, s1_v_q && s1_fwd_q, $past(s1_v_q), "forward without prior write")
  `CLBP_ASSERT_NXT(a_window_follows, s1_v_q, s2_v_q, "pipeline lost an item")
  `CLBP_ASSERT(a_code_high_zero, m_axis_tvalid, (m_axis_tdata >> n_eff) == '0, "code bits beyond N")

endmodule

`default_nettype wire
